@@ sv/avc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avc_pkg: shared types and constants for the obstacle velocity clamp
//
// Holds the table geometry, the stored rectangle layout and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package avc_pkg;

    // Table geometry.
    localparam int MAX_OBSTACLES = 16;
    localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);

    // Field widths.
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int OVL_W   = EDGE_W + 1;

    // Item kinds.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored obstacle rectangle.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } box_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted request
        logic store;    // append the captured rectangle to the table
        logic scan;     // read the next table entry into the overlap pipeline
        logic publish;  // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // table holds no obstacles
        logic scan_last;  // current scan index is the last stored entry
        logic pipe_busy;  // overlap pipeline still holds work
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage
`default_nettype wire

@@ sv/avc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avc_ctrl: sequencing state machine
//
// Accepts one request at a time, steps the datapath through a table store
// or a scan of the stored entries (none when the table is empty), and hands the result to the output register.
// ----------------------------------------------------------------------------
module avc_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          kind,
    input  wire avc_pkg::sts_t sts,
    output avc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Requests are taken only while nothing is in flight.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (kind == avc_pkg::KIND_ADD)
                        state_next = ST_ADD;
                    else if (sts.empty)
                        state_next = ST_DRAIN;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_ADD:
            begin
                cmd.store  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ sv/avc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// avc_datapath: obstacle table, overlap pipeline and result register
//
// Stores obstacle rectangles in a small memory, walks it one entry per cycle
// through a read stage, an overlap stage and a clamp stage, and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module avc_datapath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire avc_pkg::cmd_t                        cmd,
    output avc_pkg::sts_t                             sts,
    input  wire logic                                 kind,
    input  wire logic signed [avc_pkg::COORD_W-1:0]   rect_left,
    input  wire logic signed [avc_pkg::COORD_W-1:0]   rect_top,
    input  wire logic        [avc_pkg::SIZE_W-1:0]    rect_width,
    input  wire logic        [avc_pkg::SIZE_W-1:0]    rect_height,
    input  wire logic signed [avc_pkg::COORD_W-1:0]   speed_x,
    input  wire logic signed [avc_pkg::COORD_W-1:0]   speed_y,
    output logic signed      [avc_pkg::COORD_W-1:0]   new_speed_x,
    output logic signed      [avc_pkg::COORD_W-1:0]   new_speed_y,
    output logic                                      status,
    output logic                                      out_valid,
    input  wire logic                                 out_stall
);

    // Obstacle memory.
    avc_pkg::box_t table_mem [avc_pkg::MAX_OBSTACLES];

    // Captured request.
    logic          kind_reg;
    avc_pkg::box_t ent_reg;

    // Control registers.
    logic [avc_pkg::CNT_W-1:0] count_reg;
    logic [avc_pkg::IDX_W-1:0] idx_reg;
    logic                      full_reg;
    logic                      rd_vld_reg;
    logic                      ov_vld_reg;
    logic                      out_valid_reg;

    // Pipeline payload.
    avc_pkg::box_t                   rd_data_reg;
    logic signed [avc_pkg::OVL_W-1:0] ox_reg;
    logic signed [avc_pkg::OVL_W-1:0] oy_reg;
    logic                             lt_x_reg;
    logic                             lt_y_reg;
    logic signed [avc_pkg::COORD_W-1:0] vx_reg;
    logic signed [avc_pkg::COORD_W-1:0] vy_reg;
    logic signed [avc_pkg::COORD_W-1:0] out_vx_reg;
    logic signed [avc_pkg::COORD_W-1:0] out_vy_reg;
    logic                               out_status_reg;

    // Overlap stage signals.
    logic signed [avc_pkg::EDGE_W-1:0] ent_l;
    logic signed [avc_pkg::EDGE_W-1:0] ent_r;
    logic signed [avc_pkg::EDGE_W-1:0] ent_t;
    logic signed [avc_pkg::EDGE_W-1:0] ent_b;
    logic signed [avc_pkg::EDGE_W-1:0] obs_l;
    logic signed [avc_pkg::EDGE_W-1:0] obs_r;
    logic signed [avc_pkg::EDGE_W-1:0] obs_t;
    logic signed [avc_pkg::EDGE_W-1:0] obs_b;
    logic signed [avc_pkg::EDGE_W-1:0] min_r;
    logic signed [avc_pkg::EDGE_W-1:0] max_l;
    logic signed [avc_pkg::EDGE_W-1:0] min_b;
    logic signed [avc_pkg::EDGE_W-1:0] max_t;
    logic signed [avc_pkg::OVL_W-1:0]  ox;
    logic signed [avc_pkg::OVL_W-1:0]  oy;

    // Clamp stage signals.
    logic                               hit;
    logic signed [avc_pkg::COORD_W-1:0] vx_clamped;
    logic signed [avc_pkg::COORD_W-1:0] vy_clamped;

    logic table_has_room;
    logic out_take;

    assign table_has_room = (count_reg < avc_pkg::CNT_W'(avc_pkg::MAX_OBSTACLES));
    assign out_take       = out_valid_reg && !out_stall;

    // Status back to the controller.
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_last = ((avc_pkg::CNT_W'(idx_reg) + avc_pkg::CNT_W'(1)) == count_reg);
    assign sts.pipe_busy = rd_vld_reg || ov_vld_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // Edges of entity and obstacle, widened by one bit so no sum can wrap.
    always_comb
    begin
        ent_l = avc_pkg::EDGE_W'(ent_reg.left);
        ent_t = avc_pkg::EDGE_W'(ent_reg.top);
        ent_r = ent_l + $signed({2'b00, ent_reg.width});
        ent_b = ent_t + $signed({2'b00, ent_reg.height});
        obs_l = avc_pkg::EDGE_W'(rd_data_reg.left);
        obs_t = avc_pkg::EDGE_W'(rd_data_reg.top);
        obs_r = obs_l + $signed({2'b00, rd_data_reg.width});
        obs_b = obs_t + $signed({2'b00, rd_data_reg.height});
        min_r = (ent_r < obs_r) ? ent_r : obs_r;
        max_l = (ent_l > obs_l) ? ent_l : obs_l;
        min_b = (ent_b < obs_b) ? ent_b : obs_b;
        max_t = (ent_t > obs_t) ? ent_t : obs_t;
        ox    = avc_pkg::OVL_W'(min_r) - avc_pkg::OVL_W'(max_l);
        oy    = avc_pkg::OVL_W'(min_b) - avc_pkg::OVL_W'(max_t);
    end

    // Clamp on the axis of least penetration; ties go to the Y axis.
    always_comb
    begin
        hit        = ov_vld_reg && (ox_reg > 0) && (oy_reg > 0);
        vx_clamped = vx_reg;
        vy_clamped = vy_reg;
        if (hit)
        begin
            if (ox_reg < oy_reg)
            begin
                if (lt_x_reg)
                    vx_clamped = (vx_reg > 0) ? '0 : vx_reg;
                else
                    vx_clamped = (vx_reg < 0) ? '0 : vx_reg;
            end
            else
            begin
                if (lt_y_reg)
                    vy_clamped = (vy_reg > 0) ? '0 : vy_reg;
                else
                    vy_clamped = (vy_reg < 0) ? '0 : vy_reg;
            end
        end
    end

    // Table memory: write on store while there is room, registered read on scan.
    always_ff @(posedge clk)
    begin
        if (cmd.store && table_has_room)
            table_mem[count_reg[avc_pkg::IDX_W-1:0]] <= ent_reg;
        if (cmd.scan)
            rd_data_reg <= table_mem[idx_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            ov_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            ov_vld_reg <= rd_vld_reg;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                full_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                idx_reg <= idx_reg + avc_pkg::IDX_W'(1);
            end
            if (cmd.store)
            begin
                if (table_has_room)
                    count_reg <= count_reg + avc_pkg::CNT_W'(1);
                else
                    full_reg <= 1'b1;
            end
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Request capture, pipeline payload and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= kind;
            ent_reg.left   <= rect_left;
            ent_reg.top    <= rect_top;
            ent_reg.width  <= rect_width;
            ent_reg.height <= rect_height;
            vx_reg         <= speed_x;
            vy_reg         <= speed_y;
        end
        else
        begin
            vx_reg <= vx_clamped;
            vy_reg <= vy_clamped;
        end
        if (rd_vld_reg)
        begin
            ox_reg   <= ox;
            oy_reg   <= oy;
            lt_x_reg <= (ent_l < obs_l);
            lt_y_reg <= (ent_t < obs_t);
        end
        if (cmd.publish)
        begin
            if (kind_reg == avc_pkg::KIND_CHECK)
            begin
                out_vx_reg     <= vx_reg;
                out_vy_reg     <= vy_reg;
                out_status_reg <= avc_pkg::STATUS_OK;
            end
            else
            begin
                out_vx_reg     <= '0;
                out_vy_reg     <= '0;
                out_status_reg <= full_reg ? avc_pkg::STATUS_FULL : avc_pkg::STATUS_OK;
            end
        end
    end

    assign new_speed_x = out_vx_reg;
    assign new_speed_y = out_vy_reg;
    assign status      = out_status_reg;
    assign out_valid   = out_valid_reg;

endmodule
`default_nettype wire

@@ sv/aabb_velocity_clamp_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_velocity_clamp_top: obstacle table with velocity clamping
//
// Stores up to MAX_OBSTACLES obstacle rectangles and clamps an entity's
// velocity against every stored obstacle it overlaps.
// ----------------------------------------------------------------------------
// One request is handled at a time. An add request passes from acceptance
// through a store state and a finish state to a valid result. A check
// request scans every stored obstacle; the table memory has a single read
// port, and the scan reads one entry per cycle through a read, an overlap
// and a clamp stage, then drains the pipeline and finishes. A check against
// an empty table skips the scan. A stalled result holds the block in its
// finish state. The result sits in an output register, so a new request is
// taken as soon as the previous result has been loaded there. Coordinates
// are Q12.4 signed, sizes Q11.4 unsigned; edges are formed at 17 bits so
// nothing wraps.
module aabb_velocity_clamp_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                kind,
    input  wire logic signed [avc_pkg::COORD_W-1:0]  rect_left,
    input  wire logic signed [avc_pkg::COORD_W-1:0]  rect_top,
    input  wire logic        [avc_pkg::SIZE_W-1:0]   rect_width,
    input  wire logic        [avc_pkg::SIZE_W-1:0]   rect_height,
    input  wire logic signed [avc_pkg::COORD_W-1:0]  speed_x,
    input  wire logic signed [avc_pkg::COORD_W-1:0]  speed_y,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed      [avc_pkg::COORD_W-1:0]  new_speed_x,
    output logic signed      [avc_pkg::COORD_W-1:0]  new_speed_y,
    output logic                                     status
);

    avc_pkg::cmd_t cmd;
    avc_pkg::sts_t sts;

    // Sequencer.
    avc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, overlap pipeline and result register.
    avc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .speed_x     (speed_x),
        .speed_y     (speed_y),
        .new_speed_x (new_speed_x),
        .new_speed_y (new_speed_y),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the obstacle velocity clamp
//
// Fills the obstacle table with hand-placed and edge-of-range rectangles,
// then sends a long run of check requests aimed at the stored obstacles:
// overlaps, touching edges, equal overlaps and shared leading edges, mixed
// with fully random noise. Each accepted request is run through a local
// model of the table and the clamp rules. The resulting speeds and status
// are queued and compared field by field with the block's results.
// ----------------------------------------------------------------------------
module tb;

    import avc_pkg::*;

    // One request as presented to the block, with a flag that holds it back
    // until every earlier result has been returned.
    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic                      drain;
    } clamp_req_t;

    // One result: corrected speeds and add status.
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      st;
    } speed_res_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_ADD;
    logic signed [COORD_W-1:0] rect_left = '0;
    logic signed [COORD_W-1:0] rect_top = '0;
    logic        [SIZE_W-1:0]  rect_width = '0;
    logic        [SIZE_W-1:0]  rect_height = '0;
    logic signed [COORD_W-1:0] speed_x = '0;
    logic signed [COORD_W-1:0] speed_y = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] new_speed_x;
    logic signed [COORD_W-1:0] new_speed_y;
    logic                      status;

    // Stimulus and scoreboard state.
    clamp_req_t request_q[$];
    speed_res_t speed_due_q[$];
    clamp_req_t cur_req;
    box_t       gen_obst[$];
    box_t       obst_tbl[MAX_OBSTACLES];
    int         obst_cnt = 0;
    int         n_taken = 0;
    int         n_err = 0;
    int         gap_left = 0;
    int         stall_left = 0;

    aabb_velocity_clamp_top u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .speed_x     (speed_x),
        .speed_y     (speed_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_speed_x (new_speed_x),
        .new_speed_y (new_speed_y),
        .status      (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        n_err++;
        $display("tb: mismatch at result %0d: %s", n_taken, what);
    endtask

    // Applies one request to the local table and returns the result it causes.
    function automatic speed_res_t predict_clamp(input clamp_req_t r);
        speed_res_t res;
        int vx, vy, el, et, er, eb, bl, bt, br, bb, ox, oy;
        res = '0;
        res.st = STATUS_OK;
        if (r.kind == KIND_ADD)
        begin
            if (obst_cnt < MAX_OBSTACLES)
            begin
                obst_tbl[obst_cnt] = '{r.left, r.top, r.width, r.height};
                obst_cnt++;
            end
            else
            begin
                res.st = STATUS_FULL;
            end
            return res;
        end
        vx = r.vx;
        vy = r.vy;
        el = r.left;
        et = r.top;
        er = el + int'(r.width);
        eb = et + int'(r.height);
        for (int i = 0; i < obst_cnt; i++)
        begin
            bl = obst_tbl[i].left;
            bt = obst_tbl[i].top;
            br = bl + int'(obst_tbl[i].width);
            bb = bt + int'(obst_tbl[i].height);
            ox = ((er < br) ? er : br) - ((el > bl) ? el : bl);
            oy = ((eb < bb) ? eb : bb) - ((et > bt) ? et : bt);
            if (ox > 0 && oy > 0)
            begin
                // The axis with the smaller overlap is clamped; ties go to Y.
                if (ox < oy)
                    vx = (el < bl) ? ((vx < 0) ? vx : 0) : ((vx > 0) ? vx : 0);
                else
                    vy = (et < bt) ? ((vy < 0) ? vy : 0) : ((vy > 0) ? vy : 0);
            end
        end
        res.sx = 16'(vx);
        res.sy = 16'(vy);
        return res;
    endfunction

    // Decides whether an idle burst starts now. The run cycles through busy,
    // light and idle-free stretches, and the tail of the run has no idling.
    function automatic bit burst_start();
        int phase;
        phase = (n_taken / 150) % 3;
        if (request_q.size() < 200 || phase == 2)
            return 1'b0;
        return $urandom_range(0, (phase == 0) ? 3 : 15) == 0;
    endfunction

    // Queues one request and tracks which adds will land in the table.
    task automatic queue_req(input logic k, input int l, input int t, input int w,
                             input int h, input int vx, input int vy, input bit drain);
        clamp_req_t r;
        box_t       nb;
        r.kind   = k;
        r.left   = 16'(l);
        r.top    = 16'(t);
        r.width  = 15'(w);
        r.height = 15'(h);
        r.vx     = 16'(vx);
        r.vy     = 16'(vy);
        r.drain  = drain;
        request_q = {request_q, r};
        if (k == KIND_ADD && gen_obst.size() < MAX_OBSTACLES)
        begin
            nb = '{r.left, r.top, r.width, r.height};
            gen_obst = {gen_obst, nb};
        end
    endtask

    function automatic logic signed [COORD_W-1:0] rand_speed();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(0, 7))
            0: return 0;
            1, 2: return $urandom_range(0, 32767);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // Request driver: presents the next pending request and predicts its result
    // on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        logic go;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                speed_due_q = {speed_due_q, predict_clamp(cur_req)};
                n_taken++;
                if (burst_start())
                    gap_left = $urandom_range(1, 16);
            end
            if (!(in_valid && in_stall))
            begin
                go = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (request_q.size() > 0 &&
                         !(request_q[0].drain && speed_due_q.size() > 0))
                begin
                    cur_req = request_q.pop_front();
                    kind        <= cur_req.kind;
                    rect_left   <= cur_req.left;
                    rect_top    <= cur_req.top;
                    rect_width  <= cur_req.width;
                    rect_height <= cur_req.height;
                    speed_x     <= cur_req.vx;
                    speed_y     <= cur_req.vy;
                    go = 1'b1;
                end
                in_valid <= go;
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction
    // and applies random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        speed_res_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (speed_due_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = speed_due_q.pop_front();
                    if (new_speed_x !== want.sx)
                        report_mismatch($sformatf("new_speed_x got %0d, expected %0d",
                                                  new_speed_x, want.sx));
                    if (new_speed_y !== want.sy)
                        report_mismatch($sformatf("new_speed_y got %0d, expected %0d",
                                                  new_speed_y, want.sy));
                    if (status !== want.st)
                        report_mismatch($sformatf("status got %0b, expected %0b",
                                                  status, want.st));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (burst_start())
            begin
                stall_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        box_t b;
        int   ew, eh, dx, dy, bw, bh;

        // Check against an empty table: speeds pass straight through.
        queue_req(KIND_CHECK, 0, 0, 160, 160, -32768, 32767, 1'b0);
        // Square obstacle at the origin and checks around it: equal overlaps,
        // a thin X overlap from the left, touching edges, shared left edge.
        queue_req(KIND_ADD, 0, 0, 320, 320, 0, 0, 1'b0);
        queue_req(KIND_CHECK, 80, 80, 64, 64, -100, -100, 1'b0);
        queue_req(KIND_CHECK, -150, 100, 160, 64, 200, 50, 1'b0);
        queue_req(KIND_CHECK, -160, 0, 160, 160, 300, -300, 1'b0);
        queue_req(KIND_CHECK, 0, 0, 16, 320, -500, 7, 1'b0);
        // Zero-width and zero-height obstacles never overlap.
        queue_req(KIND_ADD, 1000, 1000, 0, 500, 0, 0, 1'b0);
        queue_req(KIND_ADD, 2000, 1000, 500, 0, 0, 0, 1'b0);
        queue_req(KIND_CHECK, 900, 900, 2000, 2000, -1, -1, 1'b0);
        // Rectangles at the ends of the coordinate range.
        queue_req(KIND_ADD, -32768, -32768, 32767, 32767, 0, 0, 1'b0);
        queue_req(KIND_ADD, 32767, 32767, 32767, 32767, 0, 0, 1'b0);
        queue_req(KIND_CHECK, 32000, 32000, 32767, 32767, 32767, 32767, 1'b0);
        queue_req(KIND_CHECK, -32768, -32768, 16, 32767, -32768, -32768, 1'b0);
        // Overlapping obstacle pairs.
        queue_req(KIND_ADD, -800, 400, 160, 480, 0, 0, 1'b0);
        queue_req(KIND_ADD, -800, 400, 480, 160, 0, 0, 1'b0);
        queue_req(KIND_ADD, 5000, -3000, 96, 96, 0, 0, 1'b0);
        queue_req(KIND_ADD, 5040, -2960, 96, 96, 0, 0, 1'b0);
        // A row of tiles of growing size fills the table.
        for (int i = 0; i < 7; i++)
            queue_req(KIND_ADD, -16000 + i * 4000, 8000, 64 + i * 48, 64 + i * 48,
                      0, 0, 1'b0);
        // Adds to a full table are dropped.
        queue_req(KIND_ADD, -1, -1, 32767, 32767, -1, -1, 1'b0);
        queue_req(KIND_ADD, 0, 0, 0, 0, 0, 0, 1'b0);

        // Random part: mostly checks aimed at stored obstacles, some noise.
        for (int i = 0; i < 1400; i++)
        begin
            if ($urandom_range(0, 9) == 0 || $urandom_range(0, 4) == 0)
            begin
                queue_req(($urandom_range(0, 9) == 0) ? KIND_ADD : KIND_CHECK,
                          16'($urandom), 16'($urandom), $urandom_range(0, 32767),
                          $urandom_range(0, 32767), 16'($urandom), 16'($urandom),
                          (i % 300) == 0);
            end
            else
            begin
                b  = gen_obst[$urandom_range(0, gen_obst.size() - 1)];
                bw = b.width;
                bh = b.height;
                ew = rand_size();
                eh = rand_size();
                dx = int'($urandom_range(0, ew + bw)) - ew;
                dy = int'($urandom_range(0, eh + bh)) - eh;
                case ($urandom_range(0, 4))
                    // Shared left or top edge.
                    0: dx = 0;
                    1: dy = 0;
                    // Entity lying inside the obstacle.
                    2:
                    begin
                        ew = $urandom_range(1, (bw > 0) ? bw : 1);
                        eh = $urandom_range(1, (bh > 0) ? bh : 1);
                        dx = (bw > ew) ? $urandom_range(0, bw - ew) : 0;
                        dy = (bh > eh) ? $urandom_range(0, bh - eh) : 0;
                    end
                    default: ;
                endcase
                queue_req(KIND_CHECK, int'(b.left) + dx, int'(b.top) + dy, ew, eh,
                          rand_speed(), rand_speed(), (i % 300) == 0);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() > 0 || in_valid || speed_due_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_err == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake or missing results.
    initial
    begin
        #3000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
